// ===== src/ttcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared constants and types for the text terminal with cursor and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcs_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  // Transaction modes.
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // One access to the character buffer, addressed by screen position.
  typedef struct packed {
    logic             we;
    logic             re;
    logic             rotate;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [15:0]      data;
  } buf_req_t;

endpackage

`default_nettype wire

// ===== src/text_terminal_cursor_scroll_top.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top
// Text-mode terminal: character buffer, cursor and scroll-up.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Put mode stores
// in_char_code in the current text color at the cursor and advances it;
// a newline only moves the cursor. Read mode returns the entry at
// (in_read_row, in_read_column), or zeros when that lies off the screen.
// Each transaction gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall it.
// A put without scroll gives its result in the cycle after it is taken, and
// so does a read off the screen. A read on the screen goes through the
// registered buffer read (one read through the single memory port) and then
// the output register. A put that scrolls moves rows by a rotating row
// pointer, fills the new bottom row with spaces one entry per cycle and gives
// its result after the last entry. Busy stays low after a put without scroll,
// so puts can be taken every cycle; an on-screen read holds busy for its buffer
// read, a scroll for the fill. After reset the block sweeps the whole buffer to
// grey-on-black spaces, one entry per cycle, with busy high. The color register
// is written through cfg_valid/cfg_ready and is meant to change while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_scroll_top
  import ttcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_char_code,
  input  wire logic [6:0] in_read_column,
  input  wire logic [4:0] in_read_row,
  output logic            out_valid,
  output logic [6:0]      out_cursor_column,
  output logic [4:0]      out_cursor_row,
  output logic [7:0]      out_entry_char,
  output logic [7:0]      out_entry_color,
  output logic            out_scrolled,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_text_color
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]       state_r,    state_nxt;
  logic [COL_W-1:0] cur_col_r,  cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r,  cur_row_nxt;
  logic [7:0]       color_r;
  logic [COL_W-1:0] fill_col_r, fill_col_nxt;
  logic [ROW_W-1:0] fill_row_r, fill_row_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r,  out_char_nxt;
  logic [7:0]       out_color_r, out_color_nxt;
  logic             out_scroll_r, out_scroll_nxt;

  buf_req_t    req;
  logic [15:0] rd_data;

  logic accept;
  logic is_newline;
  logic wrap;
  logic do_scroll;
  logic read_in_range;
  logic fill_col_last;
  logic fill_row_last;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state_r == ST_IDLE);

  assign is_newline    = (in_char_code == NEWLINE_CHAR);
  assign wrap          = is_newline || (cur_col_r == COL_W'(COLUMNS - 1));
  assign do_scroll     = wrap && (cur_row_r == ROW_W'(ROWS - 1));
  assign read_in_range = (int'(in_read_column) < COLUMNS) && (int'(in_read_row) < ROWS);
  assign fill_col_last = (fill_col_r == COL_W'(COLUMNS - 1));
  assign fill_row_last = (fill_row_r == ROW_W'(ROWS - 1));

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    fill_col_nxt   = fill_col_r;
    fill_row_nxt   = fill_row_r;
    out_valid_nxt  = 1'b0;
    out_char_nxt   = out_char_r;
    out_color_nxt  = out_color_r;
    out_scroll_nxt = out_scroll_r;
    req            = '0;

    case (state_r)
      ST_CLEAR: begin
        req.we   = 1'b1;
        req.row  = fill_row_r;
        req.col  = fill_col_r;
        req.data = {RESET_COLOR, SPACE_CHAR};
        if (fill_col_last) begin
          fill_col_nxt = '0;
          if (fill_row_last) begin
            fill_row_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            fill_row_nxt = fill_row_r + 1'b1;
          end
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_READ) begin
            if (read_in_range) begin
              req.re    = 1'b1;
              req.row   = ROW_W'(in_read_row);
              req.col   = COL_W'(in_read_column);
              state_nxt = ST_READ;
            end else begin
              out_valid_nxt  = 1'b1;
              out_char_nxt   = '0;
              out_color_nxt  = '0;
              out_scroll_nxt = 1'b0;
            end
          end else begin
            // The character lands on the old cursor before any scroll.
            req.we   = !is_newline;
            req.row  = cur_row_r;
            req.col  = cur_col_r;
            req.data = {color_r, in_char_code};
            out_char_nxt  = '0;
            out_color_nxt = '0;
            if (do_scroll) begin
              req.rotate   = 1'b1;
              cur_col_nxt  = '0;
              cur_row_nxt  = ROW_W'(ROWS - 1);
              fill_col_nxt = '0;
              state_nxt    = ST_FILL;
            end else begin
              if (wrap) begin
                cur_col_nxt = '0;
                cur_row_nxt = cur_row_r + 1'b1;
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
              out_valid_nxt  = 1'b1;
              out_scroll_nxt = 1'b0;
            end
          end
        end
      end

      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = rd_data[7:0];
        out_color_nxt  = rd_data[15:8];
        out_scroll_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end

      ST_FILL: begin
        // After the rotation the old top row is the new, blank bottom row.
        req.we   = 1'b1;
        req.row  = ROW_W'(ROWS - 1);
        req.col  = fill_col_r;
        req.data = {color_r, SPACE_CHAR};
        if (fill_col_last) begin
          fill_col_nxt   = '0;
          out_valid_nxt  = 1'b1;
          out_scroll_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      fill_col_r  <= '0;
      fill_row_r  <= '0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      fill_col_r  <= fill_col_nxt;
      fill_row_r  <= fill_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        color_r <= cfg_text_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_color_r  <= out_color_nxt;
    out_scroll_r <= out_scroll_nxt;
  end

  ttcs_buffer u_buffer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_cursor_column = 7'(cur_col_r);
  assign out_cursor_row    = 5'(cur_row_r);
  assign out_entry_char    = out_char_r;
  assign out_entry_color   = out_color_r;
  assign out_scrolled      = out_scroll_r;

endmodule

`default_nettype wire

// ===== src/ttcs_buffer.sv =====
// ----------------------------------------------------------------------------
// ttcs_buffer
// Character buffer memory with a rotating top-row pointer. Screen rows map to
// memory rows through the pointer, so a scroll only moves the pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_buffer
  import ttcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire buf_req_t req,
  output logic [15:0]   rd_data
);

  logic [15:0]       mem [CELLS];
  logic [ROW_W-1:0]  base_r;
  logic [ROW_W-1:0]  base_nxt;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    row_sum = {1'b0, req.row} + {1'b0, base_r};
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      phys_row = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      phys_row = ROW_W'(row_sum);
    end
    addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(req.col);
  end

  always_comb begin
    base_nxt = base_r;
    if (req.rotate) begin
      if (base_r == ROW_W'(ROWS - 1)) begin
        base_nxt = '0;
      end else begin
        base_nxt = base_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.data;
    end
    if (req.re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire
